FILE: sv/mrtu_pkg.sv
// Package for the Modbus RTU slave frame engine: op/kind codes, config indexes, CRC step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mrtu_pkg;
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_REPLY = 2'd2;

  localparam logic [1:0] KIND_TX  = 2'd0;
  localparam logic [1:0] KIND_RD  = 2'd1;
  localparam logic [1:0] KIND_WR  = 2'd2;

  localparam logic [2:0] CFG_SLAVE_ID = 3'd0;
  localparam logic [2:0] CFG_GAP      = 3'd1;
  localparam logic [2:0] CFG_CRC_EXC  = 3'd2;
  localparam logic [2:0] CFG_WIN_A    = 3'd3;
  localparam logic [2:0] CFG_WIN_E    = 3'd7;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] EXC_FUNC = 8'd1;
  localparam logic [7:0] EXC_ADDR = 8'd2;
  localparam logic [7:0] EXC_CNT  = 8'd3;
  localparam logic [7:0] EXC_FAIL = 8'd4;

  localparam logic [7:0] FC_READ  = 8'd3;
  localparam logic [7:0] FC_WRITE = 8'd6;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  rx_byte;
    logic        reply_ok;
    logic [15:0] reply_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_address;
    logic [15:0] reg_data;
    logic        last;
    logic [15:0] errors_seen;
    logic [15:0] crc_errors_seen;
  } out_item_t;

  // one bit of the reflected CRC-16 shift
  function automatic logic [15:0] crc_bit(input logic [15:0] c);
    crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction
endpackage
`default_nettype wire

FILE: sv/mrtu_if.sv
// Valid/ready stream interface carrying one payload item.
// Depends on nothing; payload type given by parameter.
`timescale 1ns / 1ps
`default_nettype none
interface mrtu_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/modbus_rtu_slave_frame_engine.sv
// Top level of the Modbus RTU slave frame engine: frame store, sequencer, output register.
// Depends on mrtu_pkg, mrtu_if and mrtu_crc.
`timescale 1ns / 1ps
`default_nettype none
// A received byte or tick is handled directly in the idle state. A decode runs the shared
// bit-serial CRC unit over six stored bytes, then checks the five windows one per cycle, and
// a reply emits up to eight bytes, one per cycle while the sink takes them; a response with
// CRC first runs the CRC unit over each covered byte. The CRC unit is the limiting part;
// input is not ready while an item is in progress.
module modbus_rtu_slave_frame_engine #(
  parameter int FRAME_LIMIT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  mrtu_if.sink             in_ch,
  mrtu_if.source           out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import mrtu_pkg::*;

  localparam logic [6:0] LIMIT = 7'(FRAME_LIMIT);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CRC   = 4'd1;  // feed stored bytes into CRC
  localparam logic [3:0] S_CHK   = 4'd2;  // compare CRC, pick path
  localparam logic [3:0] S_WIN   = 4'd3;  // window scan
  localparam logic [3:0] S_ACT   = 4'd4;  // act on decoded frame
  localparam logic [3:0] S_RCRC  = 4'd5;  // CRC over response bytes
  localparam logic [3:0] S_SEND  = 4'd6;  // emit response bytes
  localparam logic [3:0] S_REQ   = 4'd7;  // emit request
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [7:0]  slave_id, crc_exc;
  logic [15:0] gap_timeout;
  logic [31:0] windows [5];

  logic [7:0]  frame_bytes [8];
  logic [6:0]  byte_count;
  logic [15:0] idle_ticks;
  logic [1:0]  wait_mode;
  logic [7:0]  last_fc;
  logic        is_bc;
  logic [15:0] err_cnt, crc_err_cnt;

  logic [3:0]  state;
  logic [2:0]  idx;
  logic        crc_fed;
  logic [7:0]  resp [8];
  logic [3:0]  resp_len;
  logic [3:0]  crc_len;
  logic        hit;
  logic        out_valid;
  out_item_t   out_q;

  logic        crc_init, crc_feed, crc_busy;
  logic [7:0]  crc_din;
  logic [15:0] crc_val;

  mrtu_crc u_crc (
    .clk(clk), .rst(rst), .init(crc_init), .feed(crc_feed),
    .din(crc_din), .busy(crc_busy), .crc(crc_val)
  );

  in_item_t it;
  assign it = in_ch.data;
  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_q;

  logic [15:0] f_addr, f_val, win_lo, win_hi;
  assign f_addr = {frame_bytes[2], frame_bytes[3]};
  assign f_val  = {frame_bytes[4], frame_bytes[5]};
  assign win_lo = windows[idx][15:0];
  assign win_hi = windows[idx][31:16];

  // CRC unit is reloaded in every state that does not shift bytes through it
  always_comb begin
    crc_init = 1'b0;
    crc_feed = 1'b0;
    crc_din  = 8'd0;
    if (state == S_CRC || state == S_RCRC) begin
      if (!crc_busy && !crc_fed) begin
        crc_feed = 1'b1;
        crc_din  = (state == S_CRC) ? frame_bytes[idx] : resp[idx];
      end
    end else begin
      crc_init = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE_ID: slave_id <= cfg_data[7:0];
        CFG_GAP:      gap_timeout <= cfg_data[15:0];
        CFG_CRC_EXC:  crc_exc <= cfg_data[7:0];
        default: windows[cfg_index - CFG_WIN_A] <= cfg_data;
      endcase
    end
    if (rst) begin
      slave_id <= 8'd1;
      gap_timeout <= 16'd4;
      crc_exc <= 8'd0;
      for (int i = 0; i < 5; i++) windows[i] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      byte_count <= '0;
      idle_ticks <= '0;
      wait_mode <= '0;
      last_fc <= '0;
      is_bc <= 1'b0;
      err_cnt <= '0;
      crc_err_cnt <= '0;
      out_valid <= 1'b0;
      idx <= '0;
      crc_fed <= 1'b0;
      hit <= 1'b0;
      resp_len <= '0;
      crc_len <= '0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          case (it.op)
            OP_TICK: if (idle_ticks != 16'hFFFF) idle_ticks <= idle_ticks + 16'd1;
            OP_BYTE: if (wait_mode == 2'd0) begin
              logic [6:0] bc;
              bc = (idle_ticks > gap_timeout) ? 7'd0 : byte_count;
              idle_ticks <= '0;
              if (bc >= LIMIT) begin
                byte_count <= '0;
                err_cnt <= err_cnt + 16'd1;
              end else begin
                if (bc < 7'd8) frame_bytes[bc[2:0]] <= it.rx_byte;
                byte_count <= bc + 7'd1;
                if (bc + 7'd1 >= 7'd8) begin
                  is_bc <= 1'b0;
                  state <= S_FIN;
                  // decode proceeds only for own/broadcast address
                  if (((bc == 7'd0) ? it.rx_byte : frame_bytes[0]) == 8'd0 ||
                      ((bc == 7'd0) ? it.rx_byte : frame_bytes[0]) == slave_id) begin
                    is_bc <= (((bc == 7'd0) ? it.rx_byte : frame_bytes[0]) == 8'd0);
                    state <= S_CRC;
                    idx <= '0;
                    crc_fed <= 1'b0;
                  end else begin
                    is_bc <= 1'b0;
                  end
                end
              end
            end
            OP_REPLY: begin
              wait_mode <= '0;
              if (wait_mode == 2'd1 && it.reply_ok) begin
                resp[0] <= slave_id; resp[1] <= last_fc; resp[2] <= 8'd2;
                resp[3] <= it.reply_data[15:8]; resp[4] <= it.reply_data[7:0];
                resp_len <= 4'd7; crc_len <= 4'd5;
                idx <= '0; crc_fed <= 1'b0; state <= S_RCRC;
              end else if (wait_mode != 2'd0 && !it.reply_ok) begin
                err_cnt <= err_cnt + 16'd1;
                byte_count <= '0;
                if (!is_bc) begin
                  resp[0] <= slave_id; resp[1] <= last_fc | 8'h80; resp[2] <= EXC_FAIL;
                  resp_len <= 4'd5; crc_len <= 4'd3;
                  idx <= '0; crc_fed <= 1'b0; state <= S_RCRC;
                end
              end else if (wait_mode == 2'd2 && !is_bc) begin
                for (int i = 0; i < 8; i++) resp[i] <= frame_bytes[i];
                resp_len <= 4'd8; idx <= '0; state <= S_SEND;
              end
            end
            default: ;
          endcase
        end
        S_CRC, S_RCRC: begin
          if (crc_feed) crc_fed <= 1'b1;
          else if (crc_fed && !crc_busy) begin
            crc_fed <= 1'b0;
            if ({1'b0, idx} == ((state == S_CRC) ? 4'd5 : crc_len - 4'd1)) begin
              idx <= '0;
              if (state == S_CRC) state <= S_CHK;
              else begin
                resp[crc_len[2:0]] <= crc_val[7:0];
                resp[crc_len[2:0] + 3'd1] <= crc_val[15:8];
                state <= S_SEND;
              end
            end else idx <= idx + 3'd1;
          end
        end
        S_CHK: begin
          if (crc_val != {frame_bytes[7], frame_bytes[6]}) begin
            crc_err_cnt <= crc_err_cnt + 16'd1;
            err_cnt <= err_cnt + 16'd1;
            byte_count <= '0;
            state <= S_FIN;
            if (!is_bc) begin
              resp[0] <= slave_id; resp[1] <= last_fc | 8'h80; resp[2] <= crc_exc;
              resp_len <= 4'd5; crc_len <= 4'd3; crc_fed <= 1'b0; state <= S_RCRC;
            end
          end else begin
            last_fc <= frame_bytes[1];
            hit <= 1'b0; idx <= '0; state <= S_WIN;
          end
        end
        S_WIN: begin
          if (f_addr >= win_lo && f_addr <= win_hi) hit <= 1'b1;
          if (idx == 3'd4) begin idx <= '0; state <= S_ACT; end
          else idx <= idx + 3'd1;
        end
        S_ACT: begin
          logic [7:0] code;
          logic       exc;
          exc = 1'b1;
          code = EXC_FUNC;
          if (!is_bc && last_fc == FC_READ) begin
            if (!hit) code = EXC_ADDR;
            else if (f_val != 16'd1) code = EXC_CNT;
            else exc = 1'b0;
          end else if (last_fc == FC_WRITE) begin
            if (!hit) code = EXC_ADDR;
            else exc = 1'b0;
          end
          byte_count <= '0;
          if (exc) begin
            err_cnt <= err_cnt + 16'd1;
            state <= S_FIN;
            if (!is_bc) begin
              resp[0] <= slave_id; resp[1] <= last_fc | 8'h80; resp[2] <= code;
              resp_len <= 4'd5; crc_len <= 4'd3; crc_fed <= 1'b0; state <= S_RCRC;
            end
          end else begin
            wait_mode <= (last_fc == FC_READ) ? 2'd1 : 2'd2;
            state <= S_REQ;
          end
        end
        S_REQ: if (!out_valid || out_ch.ready) begin
          out_valid <= 1'b1;
          out_q.kind <= (wait_mode == 2'd1) ? KIND_RD : KIND_WR;
          out_q.tx_byte <= '0;
          out_q.reg_address <= f_addr;
          out_q.reg_data <= (wait_mode == 2'd1) ? 16'd0 : f_val;
          out_q.last <= 1'b1;
          out_q.errors_seen <= err_cnt;
          out_q.crc_errors_seen <= crc_err_cnt;
          state <= S_FIN;
        end
        S_SEND: if (!out_valid || out_ch.ready) begin
          out_valid <= 1'b1;
          out_q.kind <= KIND_TX;
          out_q.tx_byte <= resp[idx];
          out_q.reg_address <= '0;
          out_q.reg_data <= '0;
          out_q.last <= ({1'b0, idx} == resp_len - 4'd1);
          out_q.errors_seen <= err_cnt;
          out_q.crc_errors_seen <= crc_err_cnt;
          if ({1'b0, idx} == resp_len - 4'd1) begin idx <= '0; state <= S_FIN; end
          else idx <= idx + 3'd1;
        end
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/mrtu_crc.sv
// Bit-serial CRC-16 unit: one shift per cycle, byte loaded by feed, cleared by init.
// Depends on mrtu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mrtu_crc (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        init,
  input  wire logic        feed,
  input  wire logic [7:0]  din,
  output logic             busy,
  output logic [15:0]      crc
);
  import mrtu_pkg::*;
  logic [3:0] bits;
  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= '0;
      crc  <= CRC_INIT;
    end else if (init) begin
      bits <= '0;
      crc  <= CRC_INIT;
    end else if (feed) begin
      crc  <= crc ^ {8'd0, din};
      bits <= 4'd8;
    end else if (bits != 4'd0) begin
      crc  <= crc_bit(crc);
      bits <= bits - 4'd1;
    end
  end
  assign busy = (bits != 4'd0);
endmodule
`default_nettype wire

FILE: verif/modbus_rtu_slave_frame_engine_checker.sv
// Checker for the Modbus RTU slave frame engine: models frame handling, decode and replies,
// and compares every output transaction. Depends on mrtu_pkg.
`timescale 1ns / 1ps
module modbus_rtu_slave_frame_engine_checker #(
  parameter int FRAME_LIMIT = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mrtu_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mrtu_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);
  import mrtu_pkg::*;

  typedef enum logic [1:0] {AWAIT_NONE, AWAIT_READ, AWAIT_WRITE} await_t;

  logic [7:0]  own_id;
  logic [15:0] gap_limit;
  logic [7:0]  crc_exc_code;
  logic [31:0] win [5];

  logic [63:0] frame_store;
  int          frame_len;
  logic [15:0] idle_cnt;
  await_t      await_state;
  logic [7:0]  func_code;
  logic        bcast;
  logic [15:0] err_cnt;
  logic [15:0] crc_err_cnt;

  out_item_t   reply_q[$];
  out_item_t   expected_q[$];
  out_item_t   exp_item;

  initial fail_count = 0;

  function automatic logic [15:0] crc16(input logic [63:0] bytes, input int n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c ^= {8'h00, bytes[8*i +: 8]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic in_window(input logic [15:0] a);
    for (int i = 0; i < 5; i++)
      if (a >= win[i][15:0] && a <= win[i][31:16]) return 1'b1;
    return 1'b0;
  endfunction

  task automatic emit(input logic [1:0] kind, input logic [7:0] tx, input logic [15:0] addr,
                      input logic [15:0] data);
    out_item_t o;
    o = '0;
    o.kind = kind;
    o.tx_byte = tx;
    o.reg_address = addr;
    o.reg_data = data;
    reply_q.push_back(o);
  endtask

  task automatic emit_bytes(input logic [63:0] bytes, input int n);
    for (int i = 0; i < n; i++) emit(KIND_TX, bytes[8*i +: 8], 16'h0, 16'h0);
  endtask

  task automatic raise_exception(input logic [7:0] code);
    logic [63:0] r;
    logic [15:0] c;
    err_cnt++;
    if (!bcast) begin
      r = '0;
      r[7:0] = own_id;
      r[15:8] = func_code | 8'h80;
      r[23:16] = code;
      c = crc16(r, 3);
      r[39:24] = c;
      emit_bytes(r, 5);
    end
    frame_len = 0;
  endtask

  task automatic decode_frame();
    logic [15:0] addr, val;
    bcast = (frame_store[7:0] == 8'h00);
    if (frame_store[7:0] != own_id && !bcast) return;
    if (crc16(frame_store, 6) != frame_store[63:48]) begin
      crc_err_cnt++;
      raise_exception(crc_exc_code);
      return;
    end
    func_code = frame_store[15:8];
    addr = {frame_store[23:16], frame_store[31:24]};
    val = {frame_store[39:32], frame_store[47:40]};
    if (!bcast && func_code == FC_READ) begin
      if (!in_window(addr)) raise_exception(EXC_ADDR);
      else if (val != 16'd1) raise_exception(EXC_CNT);
      else begin
        emit(KIND_RD, 8'h00, addr, 16'h0);
        await_state = AWAIT_READ;
        frame_len = 0;
      end
    end else if (func_code == FC_WRITE) begin
      if (!in_window(addr)) raise_exception(EXC_ADDR);
      else begin
        emit(KIND_WR, 8'h00, addr, val);
        await_state = AWAIT_WRITE;
        frame_len = 0;
      end
    end else begin
      raise_exception(EXC_FUNC);
    end
  endtask

  task automatic predict_item(input in_item_t it);
    logic [63:0] r;
    reply_q.delete();
    case (it.op)
      OP_TICK: if (idle_cnt != 16'hFFFF) idle_cnt++;
      OP_BYTE: begin
        if (await_state == AWAIT_NONE) begin
          if (idle_cnt > gap_limit) frame_len = 0;
          idle_cnt = 0;
          if (frame_len >= FRAME_LIMIT) begin
            frame_len = 0;
            err_cnt++;
          end else begin
            if (frame_len < 8) frame_store[8*frame_len +: 8] = it.rx_byte;
            frame_len++;
            if (frame_len >= 8) decode_frame();
          end
        end
      end
      OP_REPLY: begin
        if (await_state == AWAIT_READ) begin
          await_state = AWAIT_NONE;
          if (it.reply_ok) begin
            r = '0;
            r[7:0] = own_id;
            r[15:8] = func_code;
            r[23:16] = 8'd2;
            r[31:24] = it.reply_data[15:8];
            r[39:32] = it.reply_data[7:0];
            r[55:40] = crc16(r, 5);
            emit_bytes(r, 7);
          end else begin
            raise_exception(EXC_FAIL);
          end
        end else if (await_state == AWAIT_WRITE) begin
          await_state = AWAIT_NONE;
          if (it.reply_ok) begin
            if (!bcast) emit_bytes(frame_store, 8);
          end else begin
            raise_exception(EXC_FAIL);
          end
        end
      end
      default: ;
    endcase
    foreach (reply_q[i]) begin
      reply_q[i].errors_seen = err_cnt;
      reply_q[i].crc_errors_seen = crc_err_cnt;
      reply_q[i].last = (i == reply_q.size() - 1);
      expected_q.push_back(reply_q[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0h, got %0h", name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      own_id <= 8'd1;
      gap_limit <= 16'd4;
      crc_exc_code <= 8'd0;
      for (int i = 0; i < 5; i++) win[i] <= '0;
      frame_store <= '0;
      frame_len <= 0;
      idle_cnt <= '0;
      await_state <= AWAIT_NONE;
      func_code <= '0;
      bcast <= 1'b0;
      err_cnt <= '0;
      crc_err_cnt <= '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLAVE_ID: own_id = cfg_data[7:0];
          CFG_GAP:      gap_limit = cfg_data[15:0];
          CFG_CRC_EXC:  crc_exc_code = cfg_data[7:0];
          default: if (cfg_index >= CFG_WIN_A && cfg_index <= CFG_WIN_E)
            win[cfg_index - CFG_WIN_A] = cfg_data;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected transaction: kind %0d tx_byte %0h", out_data.kind,
                 out_data.tx_byte);
          fail_count++;
        end else begin
          exp_item = expected_q.pop_front();
          check_field("kind", exp_item.kind, out_data.kind);
          check_field("tx_byte", exp_item.tx_byte, out_data.tx_byte);
          check_field("reg_address", exp_item.reg_address, out_data.reg_address);
          check_field("reg_data", exp_item.reg_data, out_data.reg_data);
          check_field("last", exp_item.last, out_data.last);
          check_field("errors_seen", exp_item.errors_seen, out_data.errors_seen);
          check_field("crc_errors_seen", exp_item.crc_errors_seen, out_data.crc_errors_seen);
        end
      end
      if (in_valid && in_ready) predict_item(in_data);
    end
    pending <= expected_q.size();
  end
endmodule

FILE: verif/modbus_rtu_slave_frame_engine_tb.sv
// Testbench top for the Modbus RTU slave frame engine: clock, reset, stimulus, verdict.
// Depends on mrtu_pkg, mrtu_if, the engine RTL and modbus_rtu_slave_frame_engine_checker.
`timescale 1ns / 1ps
module modbus_rtu_slave_frame_engine_tb;
  import mrtu_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;
  int          tx_idle;
  int          rx_idle;
  int          sent_items;
  int          cycles;

  logic [7:0]  cur_id;
  logic [15:0] cur_gap;
  logic [31:0] cur_win [5];

  mrtu_if #(.T(in_item_t))  in_ch ();
  mrtu_if #(.T(out_item_t)) out_ch ();

  modbus_rtu_slave_frame_engine u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  modbus_rtu_slave_frame_engine_checker u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= rx_idle);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [15:0] frame_crc(input logic [63:0] bytes);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < 6; i++) begin
      c ^= {8'h00, bytes[8*i +: 8]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  // unused fields of a transaction carry what the caller passes, random bits in random runs
  task automatic put_item(input logic [1:0] op, input logic [7:0] b, input logic ok,
                          input logic [15:0] d);
    in_item_t it;
    it.op = op;
    it.rx_byte = b;
    it.reply_ok = ok;
    it.reply_data = d;
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [7:0] fc, input logic [15:0] addr,
                            input logic [15:0] val, input logic bad_crc);
    logic [63:0] f;
    f = {16'h0, val[7:0], val[15:8], addr[7:0], addr[15:8], fc, id};
    f[63:48] = frame_crc(f) ^ (bad_crc ? (16'h1 << $urandom_range(15)) : 16'h0);
    for (int i = 0; i < 8; i++) put_item(OP_BYTE, f[8*i +: 8], 1'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] id, input logic [15:0] gap, input logic [7:0] code,
                            input logic [31:0] wa, input logic [31:0] wb, input logic [31:0] wc,
                            input logic [31:0] wd, input logic [31:0] we);
    logic [31:0] vals [8];
    vals = '{{24'h0, id}, {16'h0, gap}, {24'h0, code}, wa, wb, wc, wd, we};
    cur_id = id;
    cur_gap = gap;
    for (int i = 0; i < 5; i++) cur_win[i] = vals[i + 3];
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_frame();
    logic [7:0]  id, fc;
    logic [15:0] addr, val;
    int          r, w;
    // flush any leftover partial frame with a gap, most of the time
    if (cur_gap < 16 && $urandom_range(99) < 70)
      for (int i = 0; i <= cur_gap; i++)
        put_item(OP_TICK, 8'($urandom), 1'($urandom), 16'($urandom));
    r = $urandom_range(99);
    id = (r < 70) ? cur_id : (r < 80) ? 8'h00 : 8'($urandom);
    r = $urandom_range(99);
    fc = (r < 45) ? FC_READ : (r < 85) ? FC_WRITE : 8'($urandom);
    w = $urandom_range(4);
    if ($urandom_range(99) < 80 && cur_win[w][15:0] <= cur_win[w][31:16])
      addr = 16'($urandom_range(cur_win[w][31:16], cur_win[w][15:0]));
    else
      addr = 16'($urandom);
    val = (fc == FC_READ && $urandom_range(99) < 75) ? 16'd1 : 16'($urandom);
    send_frame(id, fc, addr, val, $urandom_range(99) < 12);
    r = $urandom_range(99);
    // bytes while a reply is awaited must be dropped
    if (r < 20)
      for (int i = 0; i < 2; i++) put_item(OP_BYTE, 8'($urandom), 1'($urandom), 16'($urandom));
    if (r < 85) put_item(OP_REPLY, 8'($urandom), $urandom_range(99) < 80, 16'($urandom));
    r = $urandom_range(99);
    if (r < 5) put_item(2'd3, 8'($urandom), 1'($urandom), 16'($urandom));
    else if (r < 15) put_item(OP_TICK, 8'($urandom), 1'($urandom), 16'($urandom));
  endtask

  task automatic random_run(input int count, input int tx_pct, input int rx_pct);
    int stop_at;
    tx_idle = tx_pct;
    rx_idle = rx_pct;
    stop_at = sent_items + count;
    while (sent_items < stop_at) begin
      random_frame();
      if (sent_items > stop_at - count / 2 && sent_items < stop_at - count / 2 + 10) drain();
    end
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    tx_idle = 0;
    rx_idle = 0;
    sent_items = 0;
    cycles = 0;
    cur_id = 8'd1;
    cur_gap = 16'd4;
    for (int i = 0; i < 5; i++) cur_win[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: only register 0 lies in a window
    send_frame(8'd1, FC_READ, 16'h0000, 16'd1, 1'b0);
    put_item(OP_REPLY, 8'h00, 1'b1, 16'hFFFF);
    send_frame(8'd0, FC_WRITE, 16'h0000, 16'hABCD, 1'b0);
    put_item(OP_REPLY, 8'hFF, 1'b1, 16'h0000);
    send_frame(8'd1, FC_WRITE, 16'h8000, 16'h5555, 1'b1);
    put_item(2'd3, 8'hA5, 1'b1, 16'h5A5A);
    put_item(OP_REPLY, 8'h5A, 1'b0, 16'hA5A5);
    drain();

    set_config(8'd247, 16'd0, 8'd255, 32'h00FF_0000, 32'h1FFF_1000, 32'hFFFF_FFF0,
               32'h0000_0000, 32'h0000_FFFF);
    random_run(90, 21, 48);
    set_config(8'd1, 16'hFFFF, 8'h5A, 32'hFFFF_FFFF, $urandom, $urandom, 32'h0000_0000,
               32'h0010_0008);
    random_run(90, 48, 21);
    set_config(8'($urandom_range(246, 2)), 16'd3, 8'h00, 32'hFFFF_0000, $urandom,
               32'hFFFF_FFFF, $urandom, 32'h0000_0000);
    random_run(90, 0, 0);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
